[rtl/core/bad_pkg.sv]
// Shared types and constants for the box average downscaler.
`timescale 1ns / 1ps

package bad_pkg;

  // Default sizing of the line store and the largest supported shift.
  localparam int BAD_MAX_WIDTH = 1024;
  localparam int BAD_MAX_SHIFT = 4;

  // Configuration port.
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 12;

  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SCALE_SHIFT  = 2'd2;

  // Register field widths and reset values.
  localparam int FW_W = 11;
  localparam int FH_W = 12;
  localparam int SH_W = 3;

  localparam logic [FW_W-1:0] FRAME_WIDTH_RST  = 11'd1024;
  localparam logic [FH_W-1:0] FRAME_HEIGHT_RST = 12'd768;
  localparam logic [SH_W-1:0] SCALE_SHIFT_RST  = 3'd1;

  typedef struct packed {
    logic [7:0] blue_in;
    logic [7:0] green_in;
    logic [7:0] red_in;
  } pixel_in_t;

  typedef struct packed {
    logic [7:0]  blue_avg;
    logic [7:0]  green_avg;
    logic [7:0]  red_avg;
    logic [9:0]  out_column;
    logic [11:0] out_row;
    logic        row_done;
    logic        frame_done;
  } pixel_out_t;

endpackage

[rtl/core/box_average_downscaler.sv]
// Box average downscaler: 2^k by 2^k floor-average frame shrink of an RGB stream.
`timescale 1ns / 1ps
//
// Usage
//   Pixels of a frame enter in raster order on the in_ channel (valid/ready),
//   one transaction per pixel. Each 2^k by 2^k block of input pixels yields one
//   averaged pixel on the out_ channel, tagged with its output column and row,
//   row_done on the last pixel of an output row and frame_done on the last of
//   the frame. Pixels in the right or bottom margin that do not fill a whole
//   block are consumed and dropped.
//   cfg_ is a write-only register port, always ready. Any write, whatever the
//   index, restarts the frame; write only while the block is idle.
// Timing
//   One pixel per clock sustained while the output takes its results. The result
//   of a block passes from the pixel that completes it through the line-store
//   read into stage 1, then through the add, write back and result load.
//   The line store (one entry per output column, one read and one write port)
//   sets this two-stage shape.
// Stalls and reset
//   A held result does not block input: the second stage still takes a pixel;
//   in_ready falls only when that stage holds a result that cannot move on.
//   rst_n (synchronous, active low) clears the counters, the horizontal sums
//   and the handshake state, and loads width 1024, height 768, shift 1. The
//   line store needs no clearing: each block row writes an entry before it
//   reads it back.

module box_average_downscaler
  import bad_pkg::*;
#(
  parameter int MAX_WIDTH = BAD_MAX_WIDTH,
  parameter int MAX_SHIFT = BAD_MAX_SHIFT
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // pixel input
  input  logic                  in_valid,
  output logic                  in_ready,
  input  pixel_in_t             in_data,
  // averaged pixel output
  output logic                  out_valid,
  input  logic                  out_ready,
  output pixel_out_t            out_data,
  // register writes
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int COL_W = $clog2(MAX_WIDTH);        // column counter / store index
  localparam int EW    = COL_W + 1;                // holds MAX_WIDTH itself
  localparam int WW    = (EW > FW_W) ? EW : FW_W;  // width clamp compare
  localparam int ROW_W = FH_W;
  localparam int RUN_W = 8 + MAX_SHIFT;            // horizontal sum per channel
  localparam int SUM_W = 8 + 2 * MAX_SHIFT;        // block sum per channel
  localparam int MEM_W = 3 * SUM_W;

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [FW_W-1:0] frame_width_r;
  logic [FH_W-1:0] frame_height_r;
  logic [SH_W-1:0] scale_shift_r;
  logic            cfg_wr;

  assign cfg_ready = 1'b1;
  assign cfg_wr    = cfg_valid && cfg_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_width_r  <= FRAME_WIDTH_RST;
      frame_height_r <= FRAME_HEIGHT_RST;
      scale_shift_r  <= SCALE_SHIFT_RST;
    end else if (cfg_wr) begin
      case (cfg_index)
        REG_FRAME_WIDTH:  frame_width_r  <= cfg_data[FW_W-1:0];
        REG_FRAME_HEIGHT: frame_height_r <= cfg_data[FH_W-1:0];
        REG_SCALE_SHIFT:  scale_shift_r  <= cfg_data[SH_W-1:0];
        default: ;  // unmapped index: frame restart only
      endcase
    end
  end

  // Effective (clamped) geometry.
  logic [WW-1:0]    fw_ext;
  logic [EW-1:0]    eff_w;
  logic [ROW_W-1:0] eff_h;
  logic [SH_W-1:0]  eff_s;

  always_comb begin
    fw_ext = WW'(frame_width_r);
    if (frame_width_r == '0) begin
      eff_w = EW'(1);
    end else if (fw_ext > WW'(MAX_WIDTH)) begin
      eff_w = EW'(MAX_WIDTH);
    end else begin
      eff_w = EW'(fw_ext);
    end
    eff_h = (frame_height_r == '0) ? ROW_W'(1) : frame_height_r;
    eff_s = (scale_shift_r > SH_W'(MAX_SHIFT)) ? SH_W'(MAX_SHIFT) : scale_shift_r;
  end

  // ---------------------------------------------------------------------------
  // Stage 0: position tracking, horizontal sums, line-store read
  // ---------------------------------------------------------------------------
  logic [COL_W-1:0] col_cnt_r, col_cnt_nxt;
  logic [ROW_W-1:0] row_cnt_r, row_cnt_nxt;
  logic [RUN_W-1:0] run_sum_r [3];
  logic [RUN_W-1:0] run_sum_nxt [3];

  logic [COL_W-1:0] col_mask, ox;
  logic [ROW_W-1:0] row_mask, oy;
  logic [EW-1:0]    wout, col_ext;
  logic [ROW_W-1:0] hout;
  logic             in_blk, col_first, col_last, row_first, row_last;
  logic             is_rd, is_fd;
  logic             in_acc;
  logic [7:0]       px [3];

  assign px[0] = in_data.blue_in;
  assign px[1] = in_data.green_in;
  assign px[2] = in_data.red_in;

  assign in_acc = in_valid && in_ready;

  always_comb begin
    col_mask  = ~({COL_W{1'b1}} << eff_s);
    row_mask  = ~({ROW_W{1'b1}} << eff_s);
    wout      = eff_w >> eff_s;
    hout      = eff_h >> eff_s;
    col_ext   = EW'(col_cnt_r);
    in_blk    = (col_ext < (wout << eff_s)) && (row_cnt_r < (hout << eff_s));
    col_first = (col_cnt_r & col_mask) == '0;
    col_last  = (col_cnt_r & col_mask) == col_mask;
    row_first = (row_cnt_r & row_mask) == '0;
    row_last  = (row_cnt_r & row_mask) == row_mask;
    ox        = col_cnt_r >> eff_s;
    oy        = row_cnt_r >> eff_s;
    is_rd     = EW'(ox) == (wout - EW'(1));
    is_fd     = is_rd && (oy == (hout - ROW_W'(1)));

    for (int ch = 0; ch < 3; ch++) begin
      if (col_first) begin
        run_sum_nxt[ch] = RUN_W'(px[ch]);
      end else begin
        run_sum_nxt[ch] = run_sum_r[ch] + RUN_W'(px[ch]);
      end
    end

    // raster walk with wrap at row and frame end
    if ((col_ext + EW'(1)) >= eff_w) begin
      col_cnt_nxt = '0;
      if (({1'b0, row_cnt_r} + (ROW_W+1)'(1)) >= {1'b0, eff_h}) begin
        row_cnt_nxt = '0;
      end else begin
        row_cnt_nxt = row_cnt_r + ROW_W'(1);
      end
    end else begin
      col_cnt_nxt = col_cnt_r + COL_W'(1);
      row_cnt_nxt = row_cnt_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_cnt_r <= '0;
      row_cnt_r <= '0;
      for (int ch = 0; ch < 3; ch++) run_sum_r[ch] <= '0;
    end else if (cfg_wr) begin
      col_cnt_r <= '0;
      row_cnt_r <= '0;
      for (int ch = 0; ch < 3; ch++) run_sum_r[ch] <= '0;
    end else if (in_acc) begin
      col_cnt_r <= col_cnt_nxt;
      row_cnt_r <= row_cnt_nxt;
      if (in_blk) begin
        for (int ch = 0; ch < 3; ch++) run_sum_r[ch] <= run_sum_nxt[ch];
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 1 registers: one block-column end in flight
  // ---------------------------------------------------------------------------
  logic             s1_valid_r;
  logic [COL_W-1:0] s1_addr_r;
  logic [ROW_W-1:0] s1_oy_r;
  logic             s1_first_r, s1_emit_r, s1_rd_r, s1_fd_r;
  logic             s1_adv;
  logic             s1_load;

  logic             out_valid_r;
  pixel_out_t       out_data_r;

  // The stage moves on unless it carries a result and the output is still held.
  assign s1_adv   = !(s1_emit_r && out_valid_r && !out_ready);
  assign in_ready = !s1_valid_r || s1_adv;
  assign s1_load  = in_acc && in_blk && col_last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_acc) begin
      s1_valid_r <= s1_load;
    end else if (s1_adv) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_load) begin
      s1_addr_r  <= ox;
      s1_oy_r    <= oy;
      s1_first_r <= row_first;
      s1_emit_r  <= row_last;
      s1_rd_r    <= is_rd;
      s1_fd_r    <= is_fd;
    end
  end

  // ---------------------------------------------------------------------------
  // Line store: vertical partial sums, one entry per output column
  // ---------------------------------------------------------------------------
  logic [MEM_W-1:0] col_mem [MAX_WIDTH];
  logic [MEM_W-1:0] rd_data_r;
  logic [MEM_W-1:0] wr_data;
  logic             mem_rd, mem_wr;

  assign mem_rd = s1_load && !row_first;
  assign mem_wr = s1_valid_r && s1_adv;

  always_ff @(posedge clk) begin
    if (mem_rd) begin
      rd_data_r <= col_mem[ox];
    end
    if (mem_wr) begin
      col_mem[s1_addr_r] <= wr_data;
    end
  end

  // Block-row accumulate and averaging.
  logic [SUM_W-1:0] blk_sum [3];
  logic [SUM_W-1:0] avg_full [3];
  logic [SH_W:0]    avg_sh;

  always_comb begin
    avg_sh = {eff_s, 1'b0};
    for (int ch = 0; ch < 3; ch++) begin
      if (s1_first_r) begin
        blk_sum[ch] = SUM_W'(run_sum_r[ch]);
      end else begin
        blk_sum[ch] = rd_data_r[ch*SUM_W +: SUM_W] + SUM_W'(run_sum_r[ch]);
      end
      avg_full[ch] = blk_sum[ch] >> avg_sh;
      wr_data[ch*SUM_W +: SUM_W] = blk_sum[ch];
    end
  end

  // ---------------------------------------------------------------------------
  // Output register
  // ---------------------------------------------------------------------------
  logic out_load;

  assign out_load = s1_valid_r && s1_emit_r && s1_adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data_r.blue_avg   <= avg_full[0][7:0];
      out_data_r.green_avg  <= avg_full[1][7:0];
      out_data_r.red_avg    <= avg_full[2][7:0];
      out_data_r.out_column <= 10'(s1_addr_r);
      out_data_r.out_row    <= s1_oy_r;
      out_data_r.row_done   <= s1_rd_r;
      out_data_r.frame_done <= s1_fd_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_col_in_frame: assert property (@(posedge clk) disable iff (!rst_n)
    EW'(col_cnt_r) < eff_w)
    else $error("column counter beyond frame width");

  a_row_in_frame: assert property (@(posedge clk) disable iff (!rst_n)
    row_cnt_r < eff_h)
    else $error("row counter beyond frame height");

  a_stall_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && s1_emit_r && out_valid_r && !out_ready |-> !in_ready)
    else $error("pixel taken while a result is blocked in stage 1");

  // read data only matters, and is only loaded, past the first row of a block
  a_stage_holds: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && !s1_adv |=> s1_valid_r && $stable(s1_addr_r) &&
                              (s1_first_r || $stable(rd_data_r)))
    else $error("stalled stage 1 lost its contents");

  a_frame_end_row_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_load && s1_fd_r |-> s1_rd_r)
    else $error("frame end not on a row end");

endmodule

[dv/testbench.sv]
// Self-checking testbench for the box average downscaler.
`timescale 1ns / 1ps

module testbench;
  import bad_pkg::*;

  // Index past the register list: the block only restarts its frame on it.
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

  // Allowance for the pipeline to drain, plus margin, before the block counts as idle.
  localparam int          DRAIN_CYCLES = 6;
  localparam int unsigned CYCLE_LIMIT  = 1_000_000;
  // Random stimulus stops after this many pixels.
  localparam int unsigned RAND_PIXELS  = 750;

  typedef enum logic {ROW_CFG, ROW_PIX} row_kind_t;

  // One line of the directed table: a register write or a pixel, the latter
  // optionally with its averaged pixel typed in.
  typedef struct {
    row_kind_t               kind;
    logic [CFG_IDX_W-1:0]    idx;
    logic [CFG_DATA_W-1:0]   data;
    pixel_in_t               px;
    bit                      typed;
    pixel_out_t              avg;
  } stim_row_t;

  logic                  clk;
  logic                  rst_n     = 1'b0;
  logic                  in_valid  = 1'b0;
  logic                  in_ready;
  pixel_in_t             in_data   = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  pixel_out_t            out_data;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;

  box_average_downscaler dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // ---------------------------------------------------------------------------
  // Downscaler predictor: own copy of the registers, counters and partial sums.
  // Sums are 16 bits per channel: a 16 by 16 block of 255 is 65280 at most.
  // ---------------------------------------------------------------------------
  logic [FW_W-1:0] reg_w;
  logic [FH_W-1:0] reg_h;
  logic [SH_W-1:0] reg_s;
  logic [15:0]     vsum [BAD_MAX_WIDTH][3];   // per output column, vertical sums
  logic [15:0]     hsum [3];                  // horizontal run within a block
  int unsigned     col_pos;
  int unsigned     row_pos;

  pixel_out_t      pending_avgs [$];          // averaged pixels still to arrive
  pixel_out_t      due_avg;

  int unsigned     cycles      = 0;
  int unsigned     fails       = 0;
  int unsigned     checked     = 0;
  int unsigned     pixels_sent = 0;
  int unsigned     avgs_due    = 0;
  int unsigned     reg_writes  = 0;
  int unsigned     steady_left = 0;

  // Out-of-range register values are clamped, not rejected.
  function automatic int unsigned eff_w();
    if (reg_w == 0) return 1;
    if (reg_w > BAD_MAX_WIDTH) return BAD_MAX_WIDTH;
    return reg_w;
  endfunction

  function automatic int unsigned eff_h();
    return (reg_h == 0) ? 1 : reg_h;
  endfunction

  function automatic int unsigned eff_s();
    return (reg_s > BAD_MAX_SHIFT) ? BAD_MAX_SHIFT : reg_s;
  endfunction

  task automatic reset_model();
    reg_w   = FRAME_WIDTH_RST;
    reg_h   = FRAME_HEIGHT_RST;
    reg_s   = SCALE_SHIFT_RST;
    col_pos = 0;
    row_pos = 0;
    hsum    = '{3{16'd0}};
  endtask

  // Advance the predictor by one pixel; hit says whether a block completed.
  task automatic step_model(input pixel_in_t px, output bit hit, output pixel_out_t avg);
    int unsigned w, h, s, msk, wout, hout, c, r, ox, oy;
    int          k;
    logic [7:0]  chan [3];
    w    = eff_w();
    h    = eff_h();
    s    = eff_s();
    msk  = (1 << s) - 1;
    wout = w >> s;
    hout = h >> s;
    c    = col_pos;
    r    = row_pos;
    chan[0] = px.blue_in;
    chan[1] = px.green_in;
    chan[2] = px.red_in;
    hit = 1'b0;
    avg = '0;
    // Margin pixels right of or below the last whole block are dropped.
    if (c < (wout << s) && r < (hout << s) && c < BAD_MAX_WIDTH) begin
      ox = c >> s;
      for (k = 0; k < 3; k++) begin
        hsum[k] = ((c & msk) == 0) ? 16'(chan[k]) : hsum[k] + chan[k];
      end
      if ((c & msk) == msk) begin
        // first row of a block row overwrites the line store entry
        for (k = 0; k < 3; k++) begin
          vsum[ox][k] = ((r & msk) == 0) ? hsum[k] : vsum[ox][k] + hsum[k];
        end
        if ((r & msk) == msk) begin
          oy             = r >> s;
          hit            = 1'b1;
          avg.blue_avg   = 8'(vsum[ox][0] >> (2 * s));
          avg.green_avg  = 8'(vsum[ox][1] >> (2 * s));
          avg.red_avg    = 8'(vsum[ox][2] >> (2 * s));
          avg.out_column = 10'(ox);
          avg.out_row    = 12'(oy);
          avg.row_done   = (ox == wout - 1);
          avg.frame_done = (ox == wout - 1) && (oy == hout - 1);
        end
      end
    end
    // counters wrap at the frame edges whether or not a block fits
    if (c + 1 >= w) begin
      col_pos = 0;
      row_pos = (r + 1 >= h) ? 0 : r + 1;
    end else begin
      col_pos = c + 1;
    end
  endtask

  // ---------------------------------------------------------------------------
  // Small builders for the directed table.
  // ---------------------------------------------------------------------------
  function automatic pixel_in_t rgb(input logic [7:0] b, input logic [7:0] g,
                                    input logic [7:0] r);
    pixel_in_t p;
    p.blue_in  = b;
    p.green_in = g;
    p.red_in   = r;
    return p;
  endfunction

  function automatic pixel_out_t avg_px(input logic [7:0] b, input logic [7:0] g,
                                        input logic [7:0] r, input int unsigned col,
                                        input int unsigned row, input bit rd,
                                        input bit fd);
    pixel_out_t a;
    a.blue_avg   = b;
    a.green_avg  = g;
    a.red_avg    = r;
    a.out_column = 10'(col);
    a.out_row    = 12'(row);
    a.row_done   = rd;
    a.frame_done = fd;
    return a;
  endfunction

  function automatic stim_row_t cfg_row(input logic [CFG_IDX_W-1:0] idx,
                                        input logic [CFG_DATA_W-1:0] data);
    stim_row_t t;
    t       = '{kind: ROW_CFG, default: '0};
    t.kind  = ROW_CFG;
    t.idx   = idx;
    t.data  = data;
    return t;
  endfunction

  function automatic stim_row_t pix_row(input pixel_in_t px);
    stim_row_t t;
    t      = '{kind: ROW_PIX, default: '0};
    t.kind = ROW_PIX;
    t.px   = px;
    return t;
  endfunction

  function automatic stim_row_t pix_chk(input pixel_in_t px, input pixel_out_t avg);
    stim_row_t t;
    t       = pix_row(px);
    t.typed = 1'b1;
    t.avg   = avg;
    return t;
  endfunction

  function automatic string show(input pixel_out_t a);
    return $sformatf("b=%0d g=%0d r=%0d col=%0d row=%0d rd=%0b fd=%0b", a.blue_avg,
                     a.green_avg, a.red_avg, a.out_column, a.out_row, a.row_done,
                     a.frame_done);
  endfunction

  task automatic note_fail(input string why, input pixel_out_t want, input pixel_out_t got);
    fails++;
    if (fails <= 10) $display("%s: expected %s, got %s", why, show(want), show(got));
  endtask

  // ---------------------------------------------------------------------------
  // Random helpers.
  // ---------------------------------------------------------------------------
  // Channel values lean on the extremes so the sums hit their limits.
  function automatic logic [7:0] rand_chan();
    int k;
    k = $urandom_range(0, 7);
    if (k == 0) return 8'h00;
    if (k == 1) return 8'hFF;
    return 8'($urandom_range(0, 255));
  endfunction

  // Gap before an input transaction: mostly none or short, a few long, and
  // occasional bursts with no gap at all.
  function automatic int pick_gap();
    int k;
    if (steady_left > 0) begin
      steady_left--;
      return 0;
    end
    k = $urandom_range(0, 99);
    if (k < 3) begin
      steady_left = $urandom_range(20, 60);
      return 0;
    end
    if (k < 60) return 0;
    if (k < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 30);
  endfunction

  // ---------------------------------------------------------------------------
  // Drivers.
  // ---------------------------------------------------------------------------
  // One pixel transaction. Valid stays high into the next call when there is no
  // gap, so back-to-back pixels see a single assignment per edge.
  task automatic send_pixel(input pixel_in_t px, input bit typed, input pixel_out_t want);
    int         gap;
    bit         hit;
    pixel_out_t avg;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= px;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pixels_sent++;
    step_model(px, hit, avg);
    // typed rows take the hand-worked value in place of the predictor's
    if (typed) begin
      pending_avgs.push_back(want);
      avgs_due++;
    end else if (hit) begin
      pending_avgs.push_back(avg);
      avgs_due++;
    end
  endtask

  // Drop valid, let every outstanding average come out, then let the pipeline
  // drain pixels that complete no block.
  task automatic settle();
    in_valid <= 1'b0;
    while (pending_avgs.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // One register transaction; any index restarts the frame. cfg_valid is low
  // again before the task returns, so consecutive writes never share an edge on cfg_valid.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    case (idx)
      REG_FRAME_WIDTH:  reg_w = data[FW_W-1:0];
      REG_FRAME_HEIGHT: reg_h = data[FH_W-1:0];
      REG_SCALE_SHIFT:  reg_s = data[SH_W-1:0];
      default: ;
    endcase
    col_pos = 0;
    row_pos = 0;
    hsum    = '{3{16'd0}};
    reg_writes++;
    @(posedge clk);
  endtask

  // Pick a new frame geometry, mostly whole blocks plus a ragged margin; now
  // and then an arbitrary raw value or a write to the spare index.
  task automatic new_setting(output int unsigned len);
    int unsigned s, f, w, h, k;
    k = $urandom_range(0, 19);
    s = (k < 3) ? 0 : (k < 10) ? 1 : (k < 16) ? 2 : (k < 19) ? 3 : 4;
    f = 1 << s;
    if (s == 4) begin
      w = 16 + $urandom_range(0, 3);
      h = 16 + $urandom_range(0, 2);
    end else begin
      w = f * $urandom_range(1, (s == 3) ? 3 : 8);
      h = f * $urandom_range(1, (s == 3) ? 2 : 5);
      if ($urandom_range(0, 2) == 0) w += $urandom_range(0, f - 1);
      if ($urandom_range(0, 2) == 0) h += $urandom_range(0, f - 1);
    end
    settle();
    write_reg(REG_SCALE_SHIFT, CFG_DATA_W'(s));
    write_reg(REG_FRAME_WIDTH, CFG_DATA_W'(w));
    write_reg(REG_FRAME_HEIGHT, CFG_DATA_W'(h));
    case ($urandom_range(0, 9))
      0: write_reg(REG_FRAME_WIDTH, CFG_DATA_W'($urandom_range(0, 4095)));
      1: write_reg(REG_FRAME_HEIGHT, CFG_DATA_W'($urandom_range(0, 4095)));
      2: write_reg(REG_SCALE_SHIFT, CFG_DATA_W'($urandom_range(0, 7)));
      3: write_reg(REG_SPARE, CFG_DATA_W'($urandom_range(0, 4095)));
      default: ;
    endcase
    len = eff_w() * eff_h() * $urandom_range(1, 2) + $urandom_range(0, 6);
    if (len > 400) len = 400;
    // some phases stop mid-frame, so the next write lands on a partial block
    if ($urandom_range(0, 5) == 0) len = $urandom_range(1, len);
  endtask

  // ---------------------------------------------------------------------------
  // Clock, watchdog, result-side stalls and the result checker.
  // ---------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d averages outstanding", cycles,
               pending_avgs.size());
      $display("[box_average_downscaler] ERROR");
      $finish;
    end
  end

  // Ready runs of random length with stalls: mostly short, a few long, and
  // occasional long stretches with no stall at all.
  initial begin
    int run;
    int k;
    forever begin
      k   = $urandom_range(0, 9);
      run = (k == 0) ? $urandom_range(40, 120) : $urandom_range(1, 8);
      out_ready <= 1'b1;
      repeat (run) @(posedge clk);
      k   = $urandom_range(0, 9);
      run = (k < 7) ? $urandom_range(1, 3) : (k < 9) ? $urandom_range(4, 10)
                                                   : $urandom_range(20, 40);
      out_ready <= 1'b0;
      repeat (run) @(posedge clk);
    end
  end

  // Values read here are those before the edge, so the handshake is exact.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (pending_avgs.size() == 0) begin
        note_fail("averaged pixel with none outstanding", '0, out_data);
      end else begin
        due_avg = pending_avgs.pop_front();
        checked++;
        if (out_data.blue_avg !== due_avg.blue_avg ||
            out_data.green_avg !== due_avg.green_avg ||
            out_data.red_avg !== due_avg.red_avg ||
            out_data.out_column !== due_avg.out_column ||
            out_data.out_row !== due_avg.out_row ||
            out_data.row_done !== due_avg.row_done ||
            out_data.frame_done !== due_avg.frame_done) begin
          note_fail("averaged pixel mismatch", due_avg, out_data);
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus.
  // ---------------------------------------------------------------------------
  initial begin
    stim_row_t   dir_rows [$];
    int unsigned len;
    int unsigned i;
    int unsigned rand_start;
    int unsigned left;

    reset_model();

    // Shift 0 straight after reset: each pixel is its own average.
    dir_rows.push_back(cfg_row(REG_SCALE_SHIFT, 12'd0));
    dir_rows.push_back(pix_chk(rgb(8'h00, 8'h00, 8'h00), avg_px(8'h00, 8'h00, 8'h00, 0, 0, 0, 0)));
    dir_rows.push_back(pix_chk(rgb(8'hFF, 8'hFF, 8'hFF), avg_px(8'hFF, 8'hFF, 8'hFF, 1, 0, 0, 0)));
    // One-pixel rows, then a one-pixel frame that wraps on every pixel.
    dir_rows.push_back(cfg_row(REG_FRAME_WIDTH, 12'd1));
    dir_rows.push_back(pix_chk(rgb(8'hA5, 8'h5A, 8'h3C), avg_px(8'hA5, 8'h5A, 8'h3C, 0, 0, 1, 0)));
    dir_rows.push_back(cfg_row(REG_FRAME_HEIGHT, 12'd1));
    dir_rows.push_back(pix_chk(rgb(8'hFF, 8'h00, 8'h80), avg_px(8'hFF, 8'h00, 8'h80, 0, 0, 1, 1)));
    dir_rows.push_back(pix_chk(rgb(8'h00, 8'hFF, 8'h7F), avg_px(8'h00, 8'hFF, 8'h7F, 0, 0, 1, 1)));
    // Width zero behaves as one.
    dir_rows.push_back(cfg_row(REG_FRAME_WIDTH, 12'd3));
    dir_rows.push_back(pix_chk(rgb(8'h12, 8'h34, 8'h56), avg_px(8'h12, 8'h34, 8'h56, 0, 0, 0, 0)));
    dir_rows.push_back(cfg_row(REG_FRAME_WIDTH, 12'd0));
    dir_rows.push_back(pix_chk(rgb(8'h78, 8'h9A, 8'hBC), avg_px(8'h78, 8'h9A, 8'hBC, 0, 0, 1, 1)));
    // All-ones data: 11 bits of 2047, clamped to the line store width.
    dir_rows.push_back(cfg_row(REG_FRAME_WIDTH, 12'hFFF));
    dir_rows.push_back(pix_chk(rgb(8'h01, 8'h02, 8'h03), avg_px(8'h01, 8'h02, 8'h03, 0, 0, 0, 0)));
    dir_rows.push_back(pix_chk(rgb(8'hFE, 8'hFD, 8'hFC), avg_px(8'hFE, 8'hFD, 8'hFC, 1, 0, 0, 0)));
    // Height zero behaves as one; then the tallest frame.
    dir_rows.push_back(cfg_row(REG_FRAME_WIDTH, 12'd1));
    dir_rows.push_back(cfg_row(REG_FRAME_HEIGHT, 12'd0));
    dir_rows.push_back(pix_chk(rgb(8'h11, 8'h22, 8'h33), avg_px(8'h11, 8'h22, 8'h33, 0, 0, 1, 1)));
    dir_rows.push_back(cfg_row(REG_FRAME_HEIGHT, 12'hFFF));
    dir_rows.push_back(pix_chk(rgb(8'h44, 8'h55, 8'h66), avg_px(8'h44, 8'h55, 8'h66, 0, 0, 1, 0)));
    dir_rows.push_back(pix_chk(rgb(8'h77, 8'h88, 8'h99), avg_px(8'h77, 8'h88, 8'h99, 0, 1, 1, 0)));
    // Shift 7 clamps to 4: a one-pixel-wide frame holds no whole block.
    dir_rows.push_back(cfg_row(REG_SCALE_SHIFT, 12'd7));
    dir_rows.push_back(pix_row(rgb(8'hFF, 8'hFF, 8'hFF)));
    dir_rows.push_back(pix_row(rgb(8'h80, 8'h80, 8'h80)));
    // 2x2 frame, one block: 765 / 4 floors to 191.
    dir_rows.push_back(cfg_row(REG_FRAME_WIDTH, 12'd2));
    dir_rows.push_back(cfg_row(REG_FRAME_HEIGHT, 12'd2));
    dir_rows.push_back(cfg_row(REG_SCALE_SHIFT, 12'd1));
    dir_rows.push_back(pix_row(rgb(8'h00, 8'h00, 8'h00)));
    dir_rows.push_back(pix_row(rgb(8'hFF, 8'hFF, 8'hFF)));
    dir_rows.push_back(pix_row(rgb(8'hFF, 8'hFF, 8'hFF)));
    dir_rows.push_back(pix_chk(rgb(8'hFF, 8'hFF, 8'hFF), avg_px(8'hBF, 8'hBF, 8'hBF, 0, 0, 1, 1)));
    // A write to the spare index mid-block throws the first pixel away.
    dir_rows.push_back(pix_row(rgb(8'hFF, 8'hFF, 8'hFF)));
    dir_rows.push_back(cfg_row(REG_SPARE, 12'hABC));
    dir_rows.push_back(pix_row(rgb(8'h00, 8'h00, 8'h00)));
    dir_rows.push_back(pix_row(rgb(8'h00, 8'h00, 8'h00)));
    dir_rows.push_back(pix_row(rgb(8'h01, 8'h01, 8'h01)));
    dir_rows.push_back(pix_chk(rgb(8'h02, 8'h02, 8'h02), avg_px(8'h00, 8'h00, 8'h00, 0, 0, 1, 1)));

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_rows[n]) begin
      if (dir_rows[n].kind == ROW_CFG) begin
        settle();
        write_reg(dir_rows[n].idx, dir_rows[n].data);
      end else begin
        send_pixel(dir_rows[n].px, dir_rows[n].typed, dir_rows[n].avg);
      end
    end

    // Random phases: a geometry, then whole or partial frames of pixels.
    rand_start = pixels_sent;
    while (pixels_sent - rand_start < RAND_PIXELS) begin
      new_setting(len);
      left = RAND_PIXELS - (pixels_sent - rand_start);
      if (len > left) len = left;
      for (i = 0; i < len; i++) begin
        send_pixel(rgb(rand_chan(), rand_chan(), rand_chan()), 1'b0, '0);
      end
    end

    settle();
    if (pending_avgs.size() != 0) begin
      fails += pending_avgs.size();
      $display("%0d averaged pixels never arrived, first: %s", pending_avgs.size(),
               show(pending_avgs[0]));
    end

    $display("%0d pixels over %0d register transactions; %0d of %0d averaged pixels compared",
             pixels_sent, reg_writes, checked, avgs_due);
    $display("%0d mismatches in %0d cycles", fails, cycles);
    if (fails == 0) begin
      $display("[box_average_downscaler] OK");
    end else begin
      $display("[box_average_downscaler] ERROR");
    end
    $finish;
  end

endmodule
